// ===== rtl/osp_pkg.sv =====
// Shared types and constants for the OSP frame receiver.
package osp_pkg;

    // Frame delimiters.
    localparam logic [7:0]  HDR_FIRST  = 8'hA0;
    localparam logic [7:0]  HDR_SECOND = 8'hA2;
    localparam logic [15:0] TAIL_WORD  = 16'hB0B3;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_BAD_TAIL = 2'd2,
        ST_BAD_SUM  = 2'd3
    } frame_status_t;

    // Receive phases, one-hot.
    typedef enum logic [8:0] {
        PH_HUNT0   = 9'b000000001,
        PH_HUNT1   = 9'b000000010,
        PH_LEN_HI  = 9'b000000100,
        PH_LEN_LO  = 9'b000001000,
        PH_DATA    = 9'b000010000,
        PH_CK_HI   = 9'b000100000,
        PH_CK_LO   = 9'b001000000,
        PH_TAIL_HI = 9'b010000000,
        PH_TAIL_LO = 9'b100000000
    } phase_t;

endpackage

// ===== rtl/osp_stream_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface osp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface osp_result_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;

    modport source (output valid, output out_kind, output payload_byte,
                    output frame_status, output frame_length, input ready);
    modport sink (input valid, input out_kind, input payload_byte,
                  input frame_status, input frame_length, output ready);
endinterface

// ===== rtl/osp_frame_receiver.sv =====
// Binary OSP frame receiver: header hunt, length check, payload pass-through, checksum.
//
// Usage: bytes from the serial link enter on the rx channel, one word per
// handshake. The block hunts for the header 0xA0 0xA2, reads a big-endian
// 16-bit length, and forwards each payload byte as a result word of kind
// payload. After the payload it reads a 2-byte checksum and the tail
// 0xB0 0xB3 and emits one status word: ok, bad tail or bad checksum, with
// the tail checked first. A length above max_length yields a too-long status
// word at once. Header and checksum bytes yield no result; length and tail
// bytes yield only the status words named above. Every result word carries
// the length field of the current frame. A byte is captured in the input
// register and processed while it is held there; its result word is then
// registered in the result register. Throughput is one byte per clock while
// the result receiver does not stall; the single state update of the frame
// parser sets this rate. Reset clears the parser to the hunt for the first
// header byte, sets max_length to 65535 and empties both registers. When the
// result receiver stalls, the held result and one more byte in the input
// register wait; rx.ready then drops until the result word is taken.
// max_length is to be written through cfg_wr_en / cfg_wr_data only while
// idle; the block itself does not enforce this.
module osp_frame_receiver
    import osp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    osp_byte_if.sink            rx,
    osp_result_if.source        result
);

    // Configuration register.
    logic [15:0] max_length_reg;

    // Input register.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [14:0] running_sum_reg, running_sum_next;
    logic [15:0] received_sum_reg, received_sum_next;
    logic [7:0]  tail_high_reg, tail_high_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg;
    logic [7:0]    out_byte_reg;
    frame_status_t out_status_reg;
    logic [15:0]   out_length_reg;

    // Values produced by the byte being processed.
    logic          emit;
    logic          emit_kind;
    logic [7:0]    emit_byte;
    frame_status_t emit_status;
    logic [16:0]   seen_inc;
    logic [15:0]   tail_word;

    // The byte in the input register is processed when the result register
    // is empty or its word is being taken in this cycle.
    logic advance;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready      = !in_valid_reg || advance;
    assign in_valid_next = (rx.valid && rx.ready) ? 1'b1 : (in_valid_reg && !advance);
    assign out_valid_next = advance ? emit : (out_valid_reg && !result.ready);

    assign seen_inc  = {1'b0, bytes_seen_reg} + 17'd1;
    assign tail_word = {tail_high_reg, in_byte_reg};

    always_comb
    begin
        phase_next           = phase_reg;
        declared_length_next = declared_length_reg;
        bytes_seen_next      = bytes_seen_reg;
        running_sum_next     = running_sum_reg;
        received_sum_next    = received_sum_reg;
        tail_high_next       = tail_high_reg;
        emit                 = 1'b0;
        emit_kind            = KIND_STATUS;
        emit_byte            = 8'd0;
        emit_status          = ST_OK;

        case (phase_reg)
            PH_HUNT1:
            begin
                if (in_byte_reg == HDR_SECOND)
                    phase_next = PH_LEN_HI;
                else if (in_byte_reg == HDR_FIRST)
                    phase_next = PH_HUNT1;
                else
                    phase_next = PH_HUNT0;
            end
            PH_LEN_HI:
            begin
                declared_length_next = {in_byte_reg, 8'd0};
                phase_next           = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                declared_length_next = {declared_length_reg[15:8], in_byte_reg};
                bytes_seen_next      = 16'd0;
                running_sum_next     = 15'd0;
                if (declared_length_next > max_length_reg)
                begin
                    phase_next  = PH_HUNT0;
                    emit        = 1'b1;
                    emit_status = ST_TOO_LONG;
                end
                else if (declared_length_next == 16'd0)
                    phase_next = PH_CK_HI;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                running_sum_next = running_sum_reg + {7'd0, in_byte_reg};
                bytes_seen_next  = seen_inc[15:0];
                if (seen_inc >= {1'b0, declared_length_reg})
                    phase_next = PH_CK_HI;
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                emit_byte = in_byte_reg;
            end
            PH_CK_HI:
            begin
                received_sum_next = {in_byte_reg, 8'd0};
                phase_next        = PH_CK_LO;
            end
            PH_CK_LO:
            begin
                received_sum_next = {received_sum_reg[15:8], in_byte_reg};
                phase_next        = PH_TAIL_HI;
            end
            PH_TAIL_HI:
            begin
                tail_high_next = in_byte_reg;
                phase_next     = PH_TAIL_LO;
            end
            PH_TAIL_LO:
            begin
                phase_next = PH_HUNT0;
                emit       = 1'b1;
                // A wrong tail takes precedence over a wrong checksum.
                if (tail_word != TAIL_WORD)
                    emit_status = ST_BAD_TAIL;
                else if (received_sum_reg != {1'b0, running_sum_reg})
                    emit_status = ST_BAD_SUM;
                else
                    emit_status = ST_OK;
            end
            default:
            begin
                // Hunting for the first header byte, and any stray code.
                phase_next = (in_byte_reg == HDR_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg      <= 16'hFFFF;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            phase_reg           <= PH_HUNT0;
            declared_length_reg <= 16'd0;
            bytes_seen_reg      <= 16'd0;
            running_sum_reg     <= 15'd0;
            received_sum_reg    <= 16'd0;
            tail_high_reg       <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
                max_length_reg <= cfg_wr_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg           <= phase_next;
                declared_length_reg <= declared_length_next;
                bytes_seen_reg      <= bytes_seen_next;
                running_sum_reg     <= running_sum_next;
                received_sum_reg    <= received_sum_next;
                tail_high_reg       <= tail_high_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (advance && emit)
        begin
            out_kind_reg   <= emit_kind;
            out_byte_reg   <= emit_byte;
            out_status_reg <= emit_status;
            out_length_reg <= declared_length_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_kind     = out_kind_reg;
    assign result.payload_byte = out_byte_reg;
    assign result.frame_status = out_status_reg;
    assign result.frame_length = out_length_reg;

`ifndef ASSERT_OFF
    // The input side only stalls behind a full, blocked result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("rx stalled without a blocked result");

    // A too-long frame sends the parser straight back to the hunt.
    a_too_long_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && emit_status == ST_TOO_LONG) |=> (phase_reg == PH_HUNT0))
        else $error("parser did not return to hunt after length error");

    // While in the payload phase, bytes remain to be received.
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_seen_reg < declared_length_reg))
        else $error("payload count overran the declared length");

    // Payload words never carry a status and always belong to a frame of
    // nonzero length.
    a_payload_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.out_kind == KIND_PAYLOAD) |->
            (result.frame_status == ST_OK && result.frame_length != 16'd0))
        else $error("malformed payload result word");
`endif

endmodule
